[sv/rgbhsv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared widths, constants, stage payload types and divider setup for the
// rgb to hsv converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  // fixed field widths
  localparam int CH_W  = 16;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;

  // hue constants in 2^-HUE_FRAC_BITS degree units
  localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
  localparam int HUE_GREEN  = 120 << HUE_FRAC_BITS;
  localparam int HUE_BLUE   = 240 << HUE_FRAC_BITS;
  localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
  localparam int HC_W       = $clog2(HUE_FULL + 1);

  // quotient bits: enough for both the hue sector and saturation
  localparam int HQ_W = $clog2(HUE_SECTOR + 1);
  localparam int SQ_W = FRAC_BITS + 1;
  localparam int Q_W  = (HQ_W > SQ_W) ? HQ_W : SQ_W;
  localparam int NUM_W = CH_W + Q_W;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  // after max / min search
  typedef struct packed {
    logic [CH_W-1:0] bright;
    logic [CH_W-1:0] range;
    logic [CH_W-1:0] diff;
    logic            neg;
    sel_t            sel;
    logic            gray;
    logic            black;
    logic [CH_W-1:0] alpha;
  } front_t;

  // state of both restoring dividers
  typedef struct packed {
    logic [CH_W-1:0] hrem;
    logic [Q_W-1:0]  hlow;
    logic [Q_W-1:0]  hq;
    logic [CH_W-1:0] hden;
    logic [CH_W-1:0] srem;
    logic [Q_W-1:0]  slow;
    logic [Q_W-1:0]  sq;
    logic            neg;
    sel_t            sel;
    logic            gray;
    logic            black;
    logic [CH_W-1:0] bright;
    logic [CH_W-1:0] alpha;
  } div_t;

  // numerators: diff * 60 degrees over range, range << FRAC_BITS over max
  function automatic div_t div_init(front_t f);
    logic [NUM_W-1:0] hnum;
    logic [NUM_W-1:0] snum;
    div_t d;
    hnum = NUM_W'(f.diff) * NUM_W'(HUE_SECTOR);
    snum = NUM_W'(f.range) << FRAC_BITS;
    d.hrem   = hnum[NUM_W-1:Q_W];
    d.hlow   = hnum[Q_W-1:0];
    d.hq     = '0;
    d.hden   = f.range;
    d.srem   = snum[NUM_W-1:Q_W];
    d.slow   = snum[Q_W-1:0];
    d.sq     = '0;
    d.neg    = f.neg;
    d.sel    = f.sel;
    d.gray   = f.gray;
    d.black  = f.black;
    d.bright = f.bright;
    d.alpha  = f.alpha;
    return d;
  endfunction

endpackage
`default_nettype wire

[sv/rgbhsv_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_in_if
// pixel input channel: valid / ready with rgb and alpha
// ----------------------------------------------------------------------------
interface rgbhsv_in_if;
  import rgbhsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

[sv/rgbhsv_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_out_if
// hsv result channel: valid / ready with hue, saturation, brightness, alpha
// ----------------------------------------------------------------------------
interface rgbhsv_out_if;
  import rgbhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [CH_W-1:0]  brightness;
  logic [CH_W-1:0]  alpha_out;

  modport source (output valid, hue, saturation, brightness, alpha_out, input ready);
  modport sink   (input valid, hue, saturation, brightness, alpha_out, output ready);
endinterface
`default_nettype wire

[sv/rgbhsv_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_front
// first stage: max / min, winning channel, range and signed channel difference
// ----------------------------------------------------------------------------
module rgbhsv_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          load,
  input  wire                          v_in,
  input  wire [rgbhsv_pkg::CH_W-1:0]   red,
  input  wire [rgbhsv_pkg::CH_W-1:0]   green,
  input  wire [rgbhsv_pkg::CH_W-1:0]   blue,
  input  wire [rgbhsv_pkg::CH_W-1:0]   alpha,
  output logic                         v_out,
  output rgbhsv_pkg::front_t           q_out
);
  import rgbhsv_pkg::*;

  logic            v_r;
  front_t          q_r;
  front_t          q_nxt;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] pa;
  logic [CH_W-1:0] pb;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    // ties go to red, then green
    if (red >= green && red >= blue) begin
      q_nxt.sel = SEL_RED;
      pa = green;
      pb = blue;
    end else if (green >= blue) begin
      q_nxt.sel = SEL_GREEN;
      pa = blue;
      pb = red;
    end else begin
      q_nxt.sel = SEL_BLUE;
      pa = red;
      pb = green;
    end

    q_nxt.neg    = pa < pb;
    q_nxt.diff   = (pa >= pb) ? (pa - pb) : (pb - pa);
    q_nxt.bright = mx;
    q_nxt.range  = mx - mn;
    q_nxt.gray   = mx == mn;
    q_nxt.black  = mx == '0;
    q_nxt.alpha  = alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= q_nxt;
    end
  end

  assign v_out = v_r;
  assign q_out = q_r;
endmodule
`default_nettype wire

[sv/rgbhsv_div_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_div_step
// one restoring step of the hue and saturation dividers, one quotient bit each
// ----------------------------------------------------------------------------
module rgbhsv_div_step (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     load,
  input  wire                     v_in,
  input  wire rgbhsv_pkg::div_t   d_in,
  output logic                    v_out,
  output rgbhsv_pkg::div_t        d_out
);
  import rgbhsv_pkg::*;

  logic          v_r;
  div_t          d_r;
  div_t          d_nxt;
  logic [CH_W:0] ht;
  logic [CH_W:0] st;
  logic          hbit;
  logic          sbit;

  always_comb begin
    d_nxt = d_in;
    hbit  = 1'b0;
    sbit  = 1'b0;

    // hue: remainder stays below range, so ht < 2 * range
    ht = {d_in.hrem, d_in.hlow[Q_W-1]};
    if (ht >= {1'b0, d_in.hden}) begin
      hbit       = 1'b1;
      d_nxt.hrem = CH_W'(ht - {1'b0, d_in.hden});
    end else begin
      d_nxt.hrem = ht[CH_W-1:0];
    end
    d_nxt.hlow = d_in.hlow << 1;
    d_nxt.hq   = {d_in.hq[Q_W-2:0], hbit};

    // saturation: divisor is the max
    st = {d_in.srem, d_in.slow[Q_W-1]};
    if (st >= {1'b0, d_in.bright}) begin
      sbit       = 1'b1;
      d_nxt.srem = CH_W'(st - {1'b0, d_in.bright});
    end else begin
      d_nxt.srem = st[CH_W-1:0];
    end
    d_nxt.slow = d_in.slow << 1;
    d_nxt.sq   = {d_in.sq[Q_W-2:0], sbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;
endmodule
`default_nettype wire

[sv/rgbhsv_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_out_stage
// sector offset, red wrap, gray and black cases, output register
// ----------------------------------------------------------------------------
module rgbhsv_out_stage (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               load,
  input  wire                               v_in,
  input  wire rgbhsv_pkg::div_t             d_in,
  output logic                              v_out,
  output logic [rgbhsv_pkg::HUE_W-1:0]      hue,
  output logic [rgbhsv_pkg::SAT_W-1:0]      saturation,
  output logic [rgbhsv_pkg::CH_W-1:0]       brightness,
  output logic [rgbhsv_pkg::CH_W-1:0]       alpha_out
);
  import rgbhsv_pkg::*;

  logic             v_r;
  logic [HUE_W-1:0] hue_r;
  logic [SAT_W-1:0] sat_r;
  logic [CH_W-1:0]  bright_r;
  logic [CH_W-1:0]  alpha_r;
  logic [HC_W-1:0]  q;
  logic [HC_W-1:0]  h;
  logic [HUE_W-1:0] hue_nxt;
  logic [SAT_W-1:0] sat_nxt;

  always_comb begin
    q = HC_W'(d_in.hq);
    case (d_in.sel)
      SEL_RED: begin
        if (!d_in.neg) begin
          h = q;
        end else if (q == '0) begin
          h = '0;
        end else begin
          h = HC_W'(HUE_FULL) - q;
        end
      end
      SEL_GREEN: h = d_in.neg ? HC_W'(HUE_GREEN) - q : HC_W'(HUE_GREEN) + q;
      SEL_BLUE:  h = d_in.neg ? HC_W'(HUE_BLUE) - q : HC_W'(HUE_BLUE) + q;
      default:   h = '0;
    endcase
    hue_nxt = d_in.gray ? '0 : HUE_W'(h);
    sat_nxt = d_in.black ? '0 : SAT_W'(d_in.sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= d_in.bright;
      alpha_r  <= d_in.alpha;
    end
  end

  assign v_out      = v_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bright_r;
  assign alpha_out  = alpha_r;
endmodule
`default_nettype wire

[sv/rgb_to_hsv_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pipelined rgb to hsv conversion; when not stalled, one pixel per clock
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_ch.ready is high (unsigned rgb with
// FRAC_BITS fraction bits, plus alpha) and returns hue in 2^-HUE_FRAC_BITS
// degree units, saturation as range / max with FRAC_BITS fraction bits,
// brightness = max, and alpha unchanged. Throughput is one item per cycle
// while the output is not stalled. The pipeline has one stage for the max /
// min search, Q_W stages of the two restoring dividers that run side by side,
// one quotient bit per stage, and one stage for the hue sector offset and
// output register. Hue and saturation quotients are truncated. Each stage
// holds its item when the stage after it is full and stalled, so bubbles
// close up and in_ch.ready stays high while the output register is empty or
// is being drained.
module rgb_to_hsv_converter (
  input  wire            clk,
  input  wire            rst_n,
  rgbhsv_in_if.sink      in_ch,
  rgbhsv_out_if.source   out_ch
);
  import rgbhsv_pkg::*;

  // stage 0 front, stages 1 .. Q_W divider, stage Q_W+1 output
  localparam int N_ST = Q_W + 2;

  logic [N_ST-1:0] v;
  logic [N_ST-1:0] load;
  front_t          front_q;
  div_t            dq [Q_W+1];

  // a stage takes a new item when it is empty or its item moves on
  assign load[N_ST-1] = !v[N_ST-1] || out_ch.ready;
  for (genvar k = 0; k < N_ST - 1; k++) begin : g_load
    assign load[k] = !v[k] || load[k+1];
  end

  assign in_ch.ready = load[0];

  rgbhsv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load[0]),
    .v_in  (in_ch.valid),
    .red   (in_ch.red),
    .green (in_ch.green),
    .blue  (in_ch.blue),
    .alpha (in_ch.alpha),
    .v_out (v[0]),
    .q_out (front_q)
  );

  // numerators formed on the way into the first divider step
  assign dq[0] = div_init(front_q);

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    rgbhsv_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (load[k+1]),
      .v_in  (v[k]),
      .d_in  (dq[k]),
      .v_out (v[k+1]),
      .d_out (dq[k+1])
    );
  end

  rgbhsv_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load[N_ST-1]),
    .v_in       (v[N_ST-2]),
    .d_in       (dq[Q_W]),
    .v_out      (v[N_ST-1]),
    .hue        (out_ch.hue),
    .saturation (out_ch.saturation),
    .brightness (out_ch.brightness),
    .alpha_out  (out_ch.alpha_out)
  );

  assign out_ch.valid = v[N_ST-1];

  // saturation never exceeds one
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.saturation) <= (32'd1 << FRAC_BITS)))
    else $error("saturation above one");

  // hue stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.hue) < 32'(HUE_FULL)))
    else $error("hue out of range");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.brightness == '0) |->
      (out_ch.hue == '0 && out_ch.saturation == '0))
    else $error("black pixel with nonzero hue or saturation");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire
